### src/bpba_pkg.sv
// ----------------------------------------------------------------------------
// bpba_pkg
// Shared types and constants for the block pool bump allocator.
// ----------------------------------------------------------------------------
package bpba_pkg;

    localparam int BPBA_MAX_BLOCKS = 16;

    // field widths
    localparam int SIZE_W       = 32;
    localparam int ALIGN_W      = 4;
    localparam int STATUS_W     = 2;
    localparam int OUT_IDX_W    = 4;
    localparam int CFG_IDX_W    = 2;
    localparam int IN_TDATA_W   = 32;
    localparam int IN_TUSER_W   = 2;
    localparam int OUT_TDATA_W  = 40;
    localparam int OUT_TUSER_W  = 2;

    localparam logic [ALIGN_W-1:0] ALIGN_LOG2_MAX = 4'd12;

    // register reset values
    localparam logic [SIZE_W-1:0]  DEFAULT_BLOCK_SIZE_RST = 32'd65536;
    localparam logic [ALIGN_W-1:0] ALIGNMENT_LOG2_RST     = 4'd4;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_BLOCK_SIZE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ALIGNMENT_LOG2     = 2'd1;

    // commands
    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_RESET = 1'b1;

    // result status
    localparam logic [STATUS_W-1:0] STATUS_OK         = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_ZERO_SIZE  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_TABLE_FULL = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_CLEAR,
        ST_EMIT
    } state_t;

endpackage

### src/block_pool_bump_allocator.sv
// ----------------------------------------------------------------------------
// block_pool_bump_allocator
// First-fit bump allocator over a pool of blocks kept in two on-chip RAMs.
// ----------------------------------------------------------------------------
// Flow: an allocate scans the blocks in order through the shared size/offset
//   RAM read port and checks each returned entry for a fit, stopping at the first;
//   if none fits it creates a block or reports table full, then emits the result.
//   An offset reset sweeps every block's offset to zero; a zero size goes to emit.
// Throughput: one item at a time, set by the single read port of the block RAMs;
//   a new command is taken only after the last result has left EMIT.
// Reset: synchronous active-low aresetn clears block count, FSM and valids;
//   config registers return to 65536 / 4. RAM contents are not cleared.
module block_pool_bump_allocator
    import bpba_pkg::*;
#(
    parameter int MAX_BLOCKS = BPBA_MAX_BLOCKS
) (
    input  logic                   aclk,
    input  logic                   aresetn,

    // config write channel
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [SIZE_W-1:0]      cfg_data,

    // command stream
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // [31:0] request_size
    input  logic [IN_TUSER_W-1:0]  s_tuser,   // [0] command, [1] exact_fit

    // result stream
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,   // [3:0] block_index, [35:4] alloc_offset,
                                              // [36] block_created, [39:37] zero
    output logic [OUT_TUSER_W-1:0] m_tuser    // [1:0] status
);

    localparam int IDX_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_BLOCKS);

    // ------------------------------------------------------------------
    // Config registers. Always ready; the user must write them only while idle (not enforced here).
    // ------------------------------------------------------------------
    logic [SIZE_W-1:0]  dflt_size_reg;
    logic [ALIGN_W-1:0] align_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dflt_size_reg <= DEFAULT_BLOCK_SIZE_RST;
            align_reg     <= ALIGNMENT_LOG2_RST;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_DEFAULT_BLOCK_SIZE: dflt_size_reg <= cfg_data;
                CFG_ALIGNMENT_LOG2:     align_reg     <= cfg_data[ALIGN_W-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Block RAMs: sizes and offsets, one write and one read port each.
    // The read port is shared by both and addressed by the scan counter.
    // ------------------------------------------------------------------
    logic [SIZE_W-1:0] sizes_mem [MAX_BLOCKS];
    logic [SIZE_W-1:0] offs_mem  [MAX_BLOCKS];

    logic              rd_en;
    logic [IDX_W-1:0]  rd_addr;
    logic [SIZE_W-1:0] rd_size_reg;
    logic [SIZE_W-1:0] rd_off_reg;

    logic              size_we;
    logic              off_we;
    logic [IDX_W-1:0]  wr_addr;
    logic [SIZE_W-1:0] size_wdata;
    logic [SIZE_W-1:0] off_wdata;

    always_ff @(posedge aclk) begin
        if (size_we) begin
            sizes_mem[wr_addr] <= size_wdata;
        end
        if (off_we) begin
            offs_mem[wr_addr] <= off_wdata;
        end
        if (rd_en) begin
            rd_size_reg <= sizes_mem[rd_addr];
            rd_off_reg  <= offs_mem[rd_addr];
        end
    end

    // ------------------------------------------------------------------
    // Control and held item
    // ------------------------------------------------------------------
    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  step_reg, step_next;      // scan issue / clear sweep
    logic              pend_valid_reg, pend_valid_next;
    logic [IDX_W-1:0]  pend_idx_reg, pend_idx_next;

    logic              cmd_reg, cmd_next;
    logic [SIZE_W-1:0] req_reg, req_next;
    logic              exact_reg, exact_next;

    // pending result, waits in EMIT for the output register
    logic [STATUS_W-1:0]  res_status_reg, res_status_next;
    logic [OUT_IDX_W-1:0] res_idx_reg, res_idx_next;
    logic [SIZE_W-1:0]    res_off_reg, res_off_next;
    logic                 res_created_reg, res_created_next;

    // output register
    logic                 m_tvalid_reg, m_tvalid_next;
    logic [STATUS_W-1:0]  out_status_reg, out_status_next;
    logic [OUT_IDX_W-1:0] out_idx_reg, out_idx_next;
    logic [SIZE_W-1:0]    out_off_reg, out_off_next;
    logic                 out_created_reg, out_created_next;

    logic s_accept;
    logic out_free;
    logic emit_load;

    assign s_accept  = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign emit_load = (state_reg == ST_EMIT) && out_free;

    // ------------------------------------------------------------------
    // Fit check on the entry that came back from the RAM
    // ------------------------------------------------------------------
    logic [ALIGN_W-1:0]  align_sh;
    logic [SIZE_W:0]     align_mask;
    logic [SIZE_W:0]     aligned_off;   // may pass 32 bits
    logic [SIZE_W+1:0]   end_off;
    logic                fits;
    logic                hit;
    logic                have_more;
    logic                full;
    logic [SIZE_W-1:0]   new_size;
    logic [IDX_W+OUT_IDX_W-1:0] pend_idx_wide;
    logic [IDX_W+OUT_IDX_W-1:0] cnt_idx_wide;

    always_comb begin
        align_sh    = (align_reg > ALIGN_LOG2_MAX) ? ALIGN_LOG2_MAX : align_reg;
        align_mask  = (SIZE_W + 1)'(((SIZE_W + 1)'(1) << align_sh) - (SIZE_W + 1)'(1));
        aligned_off = ({1'b0, rd_off_reg} + align_mask) & ~align_mask;
        end_off     = {1'b0, aligned_off} + {2'b00, req_reg};
        fits        = end_off <= {2'b00, rd_size_reg};
        hit         = pend_valid_reg && fits && (!exact_reg || (rd_size_reg == req_reg));
        have_more   = step_reg < count_reg;
        full        = count_reg == CNT_MAX;
        if (exact_reg) begin
            new_size = req_reg;
        end else begin
            new_size = (dflt_size_reg > req_reg) ? dflt_size_reg : req_reg;
        end
        pend_idx_wide = {{OUT_IDX_W{1'b0}}, pend_idx_reg};
        cnt_idx_wide  = {{OUT_IDX_W{1'b0}}, count_reg[IDX_W-1:0]};
    end

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    if (s_tuser[0] == CMD_RESET) begin
                        state_next = ST_CLEAR;
                    end else if (s_tdata[SIZE_W-1:0] == '0) begin
                        state_next = ST_EMIT;
                    end else begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (hit || !have_more) begin
                    state_next = ST_EMIT;
                end
            end
            ST_CLEAR: begin
                if (!have_more) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Outputs and datapath
    // ------------------------------------------------------------------
    always_comb begin
        s_tready         = (state_reg == ST_IDLE);

        count_next       = count_reg;
        step_next        = step_reg;
        pend_valid_next  = pend_valid_reg;
        pend_idx_next    = pend_idx_reg;
        cmd_next         = cmd_reg;
        req_next         = req_reg;
        exact_next       = exact_reg;
        res_status_next  = res_status_reg;
        res_idx_next     = res_idx_reg;
        res_off_next     = res_off_reg;
        res_created_next = res_created_reg;

        rd_en      = 1'b0;
        rd_addr    = step_reg[IDX_W-1:0];
        size_we    = 1'b0;
        off_we     = 1'b0;
        wr_addr    = step_reg[IDX_W-1:0];
        size_wdata = new_size;
        off_wdata  = '0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    cmd_next         = s_tuser[0];
                    exact_next       = s_tuser[1];
                    req_next         = s_tdata[SIZE_W-1:0];
                    step_next        = '0;
                    pend_valid_next  = 1'b0;
                    res_status_next  = STATUS_OK;
                    res_idx_next     = '0;
                    res_off_next     = '0;
                    res_created_next = 1'b0;
                    if (s_tuser[0] == CMD_ALLOC && s_tdata[SIZE_W-1:0] == '0) begin
                        res_status_next = STATUS_ZERO_SIZE;
                    end
                end
            end
            ST_SCAN: begin
                if (hit) begin
                    // first fit: bump this block's offset
                    off_we           = 1'b1;
                    wr_addr          = pend_idx_reg;
                    off_wdata        = end_off[SIZE_W-1:0];
                    res_status_next  = STATUS_OK;
                    res_idx_next     = pend_idx_wide[OUT_IDX_W-1:0];
                    res_off_next     = aligned_off[SIZE_W-1:0];
                    pend_valid_next  = 1'b0;
                end else if (have_more) begin
                    rd_en           = 1'b1;
                    pend_valid_next = 1'b1;
                    pend_idx_next   = step_reg[IDX_W-1:0];
                    step_next       = step_reg + 1'b1;
                end else begin
                    // no block fits
                    pend_valid_next = 1'b0;
                    if (full) begin
                        res_status_next = STATUS_TABLE_FULL;
                    end else begin
                        size_we          = 1'b1;
                        off_we           = 1'b1;
                        wr_addr          = count_reg[IDX_W-1:0];
                        size_wdata       = new_size;
                        off_wdata        = req_reg;
                        count_next       = count_reg + 1'b1;
                        res_status_next  = STATUS_OK;
                        res_idx_next     = cnt_idx_wide[OUT_IDX_W-1:0];
                        res_off_next     = '0;
                        res_created_next = 1'b1;
                    end
                end
            end
            ST_CLEAR: begin
                if (have_more) begin
                    off_we    = 1'b1;
                    wr_addr   = step_reg[IDX_W-1:0];
                    off_wdata = '0;
                    step_next = step_reg + 1'b1;
                end
            end
            ST_EMIT: ;
            default: ;
        endcase

        // output register
        m_tvalid_next    = m_tvalid_reg && !m_tready;
        out_status_next  = out_status_reg;
        out_idx_next     = out_idx_reg;
        out_off_next     = out_off_reg;
        out_created_next = out_created_reg;
        if (emit_load) begin
            m_tvalid_next    = 1'b1;
            out_status_next  = res_status_reg;
            out_idx_next     = res_idx_reg;
            out_off_next     = res_off_reg;
            out_created_next = res_created_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            count_reg      <= '0;
            step_reg       <= '0;
            pend_valid_reg <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            step_reg       <= step_next;
            pend_valid_reg <= pend_valid_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pend_idx_reg    <= pend_idx_next;
        cmd_reg         <= cmd_next;
        req_reg         <= req_next;
        exact_reg       <= exact_next;
        res_status_reg  <= res_status_next;
        res_idx_reg     <= res_idx_next;
        res_off_reg     <= res_off_next;
        res_created_reg <= res_created_next;
        out_status_reg  <= out_status_next;
        out_idx_reg     <= out_idx_next;
        out_off_reg     <= out_off_next;
        out_created_reg <= out_created_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {3'b000, out_created_reg, out_off_reg, out_idx_reg};
    assign m_tuser  = out_status_reg;

`ifndef SYNTHESIS
    // block count never passes the table depth
    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_MAX)
        else $error("block count above table depth");

    // the table only grows, one block at a time, and only on allocate
    assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg != $past(count_reg)) |->
            ((count_reg == CNT_W'($past(count_reg) + 1'b1)) && (cmd_reg == CMD_ALLOC)))
        else $error("block count changed by other than one allocate");

    // table full is only reported with every block in use
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && (out_status_reg == STATUS_TABLE_FULL)) |-> full)
        else $error("table full reported with free entries");

    // a created block always comes with ok status and offset zero
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && out_created_reg) |->
            ((out_status_reg == STATUS_OK) && (out_off_reg == '0)))
        else $error("bad result for created block");

    // no RAM read and write collide in one cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        rd_en |-> !(off_we || size_we))
        else $error("RAM read and write in same cycle");
`endif

endmodule

### bench/block_pool_bump_allocator_tb.sv
// ----------------------------------------------------------------------------
// block_pool_bump_allocator_tb
// Self-checking bench for the first-fit bump allocator: drives allocate and
// offset-reset beats with random gaps, keeps a shadow block table to predict
// every grant, and compares each result beat field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

// Shadow of the block table plus the queue of grants still owed by the DUT.
class bump_pool_model;

    typedef struct packed {
        logic [bpba_pkg::STATUS_W-1:0]  status;
        logic [bpba_pkg::OUT_IDX_W-1:0] block_index;
        logic [bpba_pkg::SIZE_W-1:0]    alloc_offset;
        logic                           block_created;
    } grant_t;

    logic [31:0] blk_size [bpba_pkg::BPBA_MAX_BLOCKS];
    logic [31:0] blk_off  [bpba_pkg::BPBA_MAX_BLOCKS];
    int          blk_count;
    logic [31:0] dflt_size;
    logic [3:0]  align_log2;
    grant_t      owed_grants [$];
    int          errors;

    function new();
        blk_count  = 0;
        dflt_size  = bpba_pkg::DEFAULT_BLOCK_SIZE_RST;
        align_log2 = bpba_pkg::ALIGNMENT_LOG2_RST;
        errors     = 0;
    endfunction

    function int pending();
        return owed_grants.size();
    endfunction

    function int blocks_used();
        return blk_count;
    endfunction

    function void write_register(logic [1:0] idx, logic [31:0] data);
        if (idx == bpba_pkg::CFG_DEFAULT_BLOCK_SIZE)
            dflt_size = data;
        else if (idx == bpba_pkg::CFG_ALIGNMENT_LOG2)
            align_log2 = data[3:0];
    endfunction

    // Predict the grant for one accepted command beat and queue it.
    function void accept_command(logic cmd, logic [31:0] req, logic exact);
        grant_t      g;
        logic [32:0] mask;
        logic [32:0] aligned;
        logic [32:0] fin;
        int          shift;
        bit          found;
        g = '{status: bpba_pkg::STATUS_OK, block_index: '0,
              alloc_offset: '0, block_created: 1'b0};
        if (cmd == bpba_pkg::CMD_RESET) begin
            for (int i = 0; i < blk_count; i++)
                blk_off[i] = '0;
        end else if (req == '0) begin
            g.status = bpba_pkg::STATUS_ZERO_SIZE;
        end else begin
            // alignment codes above the max saturate
            shift = (align_log2 > bpba_pkg::ALIGN_LOG2_MAX) ?
                    int'(bpba_pkg::ALIGN_LOG2_MAX) : int'(align_log2);
            mask  = (33'd1 << shift) - 33'd1;
            found = 1'b0;
            for (int i = 0; i < blk_count; i++) begin
                if (!found && (!exact || blk_size[i] == req)) begin
                    // 33-bit sums: a rounded offset past 2^32 never fits
                    aligned = ({1'b0, blk_off[i]} + mask) & ~mask;
                    fin     = aligned + {1'b0, req};
                    if (fin <= {1'b0, blk_size[i]}) begin
                        blk_off[i]     = fin[31:0];
                        g.block_index  = 4'(i);
                        g.alloc_offset = aligned[31:0];
                        found          = 1'b1;
                    end
                end
            end
            if (!found) begin
                if (blk_count >= bpba_pkg::BPBA_MAX_BLOCKS) begin
                    g.status = bpba_pkg::STATUS_TABLE_FULL;
                end else begin
                    if (exact)
                        blk_size[blk_count] = req;
                    else
                        blk_size[blk_count] = (dflt_size > req) ? dflt_size : req;
                    blk_off[blk_count] = req;
                    g.block_index      = 4'(blk_count);
                    g.block_created    = 1'b1;
                    blk_count++;
                end
            end
        end
        owed_grants.push_back(g);
    endfunction

    function void check_grant(logic [1:0] status, logic [3:0] idx,
                              logic [31:0] offset, logic created);
        grant_t g;
        if (owed_grants.size() == 0) begin
            $error("result beat with no grant pending");
            errors++;
            return;
        end
        g = owed_grants.pop_front();
        if (status !== g.status) begin
            $error("status: expected %0d, got %0d", g.status, status);
            errors++;
        end
        if (idx !== g.block_index) begin
            $error("block_index: expected %0d, got %0d", g.block_index, idx);
            errors++;
        end
        if (offset !== g.alloc_offset) begin
            $error("alloc_offset: expected 0x%08h, got 0x%08h", g.alloc_offset, offset);
            errors++;
        end
        if (created !== g.block_created) begin
            $error("block_created: expected %0d, got %0d", g.block_created, created);
            errors++;
        end
    endfunction

endclass

module block_pool_bump_allocator_tb;
    import bpba_pkg::*;

    localparam int  CLK_PERIOD  = 20;
    localparam int  CYCLE_LIMIT = 400000;
    localparam int  TAIL_CYCLES = 30;     // wait after the final drain before the verdict
    // indexes past the register map, writes must be dropped
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

    logic                   aclk;
    logic                   aresetn;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [SIZE_W-1:0]      cfg_data;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;     // [31:0] request_size
    logic [IN_TUSER_W-1:0]  s_tuser;     // [0] command, [1] exact_fit
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;     // [3:0] block_index, [35:4] alloc_offset,
                                         // [36] block_created, [39:37] zero
    logic [OUT_TUSER_W-1:0] m_tuser;     // [1:0] status

    bump_pool_model pool;
    bit             no_idle;             // forces back-to-back beats on both sides
    int             cycle_count;

    block_pool_bump_allocator u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #(CLK_PERIOD / 2) aclk = ~aclk;
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Gap length in cycles: mostly none or short, now and then long.
    function automatic int gap_len();
        int r;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 4);
        return $urandom_range(10, 40);
    endfunction

    // Result side: bursts of ready with random stalls between them.
    initial begin
        int n;
        m_tready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            @(negedge aclk);
            m_tready = 1'b1;
            repeat ($urandom_range(1, 12)) @(negedge aclk);
            n = gap_len();
            if (n > 0) begin
                m_tready = 1'b0;
                repeat (n - 1) @(negedge aclk);
            end
        end
    end

    // Result monitor: every accepted beat is checked against the oldest grant.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            pool.check_grant(m_tuser[1:0], m_tdata[3:0], m_tdata[35:4], m_tdata[36]);
    end

    // One command beat; tvalid stays high if the next beat follows with no gap.
    task automatic send_item(input logic cmd, input logic [31:0] req, input logic exact);
        int gap;
        gap = gap_len();
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tdata  = req;
        s_tuser  = {exact, cmd};
        s_tvalid = 1'b1;
        do @(posedge aclk); while (!s_tready);
        pool.accept_command(cmd, req, exact);
    endtask

    // Stop sending and hold off until every owed grant has come back.
    task automatic drain_results();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (pool.pending() != 0) @(posedge aclk);
    endtask

    // Register writes only ever happen with the allocator idle.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
        drain_results();
        @(negedge aclk);
        cfg_index = idx;
        cfg_data  = data;
        cfg_valid = 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        pool.write_register(idx, data);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    // Pool of sizes shared by exact-fit requests so they sometimes reuse a block.
    function automatic logic [31:0] pool_size();
        case ($urandom_range(0, 3))
            0:       return 32'd16;
            1:       return 32'd256;
            2:       return 32'd4096;
            default: return 32'd65536;
        endcase
    endfunction

    task automatic send_random_item();
        int          r;
        int          s;
        logic        exact;
        logic [31:0] req;
        r = $urandom_range(0, 99);
        if (r < 8) begin
            // offset reset, payload is don't-care
            send_item(CMD_RESET, $urandom, 1'($urandom));
        end else if (r < 12) begin
            send_item(CMD_ALLOC, 32'd0, 1'($urandom));
        end else begin
            exact = ($urandom_range(0, 99) < 15);
            s     = $urandom_range(0, 99);
            if (exact)
                req = (s < 70) ? pool_size() : $urandom_range(1, 256);
            else if (s < 55)
                req = $urandom_range(1, 256);
            else if (s < 75)
                req = $urandom_range(257, 8192);
            else if (s < 85)
                req = pool_size();
            else if (s < 93)
                req = $urandom_range(60000, 70000);
            else
                req = $urandom;   // huge, mostly forces a new block
            send_item(CMD_ALLOC, req, exact);
        end
    endtask

    // Random phase with a mid-phase drain and a stretch of no idling.
    task automatic run_random(input int n);
        for (int k = 0; k < n; k++) begin
            if (k == n / 2)
                drain_results();
            no_idle = (k >= (n * 2) / 3) && (k < (n * 5) / 6);
            send_random_item();
        end
        no_idle = 1'b0;
    endtask

    initial begin
        pool        = new();
        no_idle     = 1'b0;
        cycle_count = 0;
        aresetn     = 1'b0;
        cfg_valid   = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = '0;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // ---- directed: reset register values ----
        send_item(CMD_ALLOC, 32'd0, 1'b0);            // zero size
        send_item(CMD_ALLOC, 32'd0, 1'b1);            // zero size, exact
        send_item(CMD_RESET, 32'hFFFF_FFFF, 1'b1);    // reset with empty table
        send_item(CMD_ALLOC, 32'd1, 1'b0);            // first block
        send_item(CMD_ALLOC, 32'd100, 1'b0);          // bump with rounding
        send_item(CMD_ALLOC, 32'd65536, 1'b0);        // no room -> new block
        send_item(CMD_ALLOC, 32'd65536, 1'b1);        // exact, no room -> new block
        send_item(CMD_ALLOC, 32'hFFFF_FFFF, 1'b0);    // largest request
        send_item(CMD_ALLOC, 32'd1, 1'b0);
        send_item(CMD_RESET, 32'h5A5A_A5A5, 1'b0);
        send_item(CMD_ALLOC, 32'hFFFF_FFFF, 1'b1);    // exact hit on largest block
        send_item(CMD_RESET, 32'd0, 1'b0);
        send_item(CMD_ALLOC, 32'hFFFF_FFF5, 1'b0);    // leaves an offset near 2^32
        send_item(CMD_ALLOC, 32'd70000, 1'b0);        // rounding past 2^32 must not fit
        send_item(CMD_ALLOC, 32'd70000, 1'b1);

        // zero default size: normal-mode block gets exactly the request
        write_reg(CFG_DEFAULT_BLOCK_SIZE, 32'd0);
        write_reg(CFG_ALIGNMENT_LOG2, 32'd0);
        send_item(CMD_ALLOC, 32'd100001, 1'b0);
        send_item(CMD_ALLOC, 32'd3, 1'b0);
        send_item(CMD_ALLOC, 32'd5, 1'b0);

        // alignment code above range saturates at 4 KiB
        write_reg(CFG_DEFAULT_BLOCK_SIZE, 32'd1);
        write_reg(CFG_ALIGNMENT_LOG2, 32'd15);
        send_item(CMD_ALLOC, 32'd7, 1'b0);
        send_item(CMD_ALLOC, 32'd5, 1'b0);
        send_item(CMD_ALLOC, 32'd200000, 1'b0);

        // ---- random phases over several register settings ----
        write_reg(CFG_DEFAULT_BLOCK_SIZE, 32'd4096);
        write_reg(CFG_ALIGNMENT_LOG2, 32'd0);
        run_random(90);

        write_reg(CFG_DEFAULT_BLOCK_SIZE, 32'd1);
        write_reg(CFG_ALIGNMENT_LOG2, 32'd12);
        run_random(90);

        write_reg(CFG_DEFAULT_BLOCK_SIZE, 32'hFFFF_FFFF);
        write_reg(CFG_ALIGNMENT_LOG2, 32'd13);
        run_random(90);

        // spare indexes must not disturb the registers
        write_reg(CFG_DEFAULT_BLOCK_SIZE, DEFAULT_BLOCK_SIZE_RST);
        write_reg(CFG_ALIGNMENT_LOG2, 32'd4);
        write_reg(CFG_SPARE_A, $urandom);
        write_reg(CFG_SPARE_B, 32'hFFFF_FFFF);
        run_random(90);

        // upper data bits beyond the alignment field are dropped
        write_reg(CFG_DEFAULT_BLOCK_SIZE, 32'd0);
        write_reg(CFG_ALIGNMENT_LOG2, {28'($urandom_range(1, 32'h0FFF_FFFF)), 4'd3});
        run_random(90);

        // ---- fill any free entries, then hit the full table ----
        while (pool.blocks_used() < BPBA_MAX_BLOCKS)
            send_item(CMD_ALLOC, 32'h8000_0000 + $urandom_range(1, 1 << 20), 1'b1);
        send_item(CMD_ALLOC, 32'h7FFF_FFFF, 1'b1);
        send_item(CMD_ALLOC, 32'hFFFF_FFFF, 1'b0);
        send_item(CMD_RESET, $urandom, 1'b0);
        send_item(CMD_ALLOC, 32'd1, 1'b0);

        drain_results();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (pool.errors == 0 && pool.pending() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
